// ===== sv/itgb_pkg.sv =====
package itgb_pkg;

    // Build-time defaults
    localparam int CAL_SAMPLES_DEF  = 1000;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;

    // Fixed scale factors
    localparam int GYRO_LSB_PER_DPS = 131;
    localparam int TILT_LIMIT       = 23040;

    // ceil(2^32 / 131): the top bits of n * GYRO_RECIP give n / 131 exactly for n < 2^24
    localparam logic [24:0] GYRO_RECIP = 25'd32786010;

    // Item kinds on tuser
    typedef enum logic [1:0] {
        CMD_MEASURE = 2'd0,
        CMD_CAL     = 2'd1,
        CMD_FINISH  = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    // atan(2^-i) in degrees * 2^16, rounded
    function automatic logic [21:0] atan_entry(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/imu_tilt_and_gyro_bias_unit.sv =====
// Six-axis IMU front end: a calibration item (tuser 1) adds its gyro axes to running sums
// and a finish item (tuser 2) turns the sums into biases through a shared bit-serial
// restoring divider, one quotient bit a cycle, three divisions of an NW-bit dividend
// (NW = 24 + clog2(CAL_SAMPLES+1), 34 by default), or only clears the sums when no samples
// were taken; a measure item scales the rates by reciprocal multiply (one axis a cycle),
// forms ay^2+az^2 in the multiplier, takes a bit-pair square root, runs the CORDIC
// rotation (skipped when acc X is zero) and then loads the output register. Item kind 3
// is dropped. The input is not ready while an item is in work; a finished measure item
// waits in the output register while the next input item is taken, and a measure item
// stalls before its output load while that register still holds an item not yet taken.
module imu_tilt_and_gyro_bias_unit #(
    parameter int CAL_SAMPLES  = itgb_pkg::CAL_SAMPLES_DEF,
    parameter int CORDIC_STEPS = itgb_pkg::CORDIC_STEPS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // acc_x_raw, acc_y_raw, acc_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw (16 bits each)
    input  logic [95:0]  s_tdata,
    // cmd
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // acc_x_g, acc_y_g, acc_z_g (16 each), rate_x, rate_y, rate_z (18 each),
    // tilt_angle (16), 2 zero bits
    output logic [119:0] m_tdata
);
    import itgb_pkg::*;

    localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
    localparam int SUM_W = 16 + CNT_W;
    localparam int NW    = SUM_W + 8;
    localparam int DW    = (CNT_W > 8) ? CNT_W : 8;
    localparam int DC_W  = $clog2(NW);
    localparam int STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam int IC_W  = $clog2(STEPS);
    localparam int XW    = 36;
    localparam int ZW    = 25;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_SQ   = 6'b000100,
        S_SQRT = 6'b001000,
        S_CORD = 6'b010000,
        S_HOLD = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic signed [SUM_W-1:0] sum_reg [3];
    logic [CNT_W-1:0]        count_reg;
    logic signed [23:0]      bias_reg [3];
    logic signed [17:0]      rate_reg [3];
    logic signed [15:0]      acc_reg [3];
    logic signed [15:0]      gyro_reg [3];
    logic                    fin_reg;
    logic [1:0]              axis_reg;

    logic                    div_ld_reg;
    logic [DC_W-1:0]         div_cnt_reg;
    logic [NW-1:0]           dvd_reg;
    logic [DW-1:0]           rem_reg;
    logic [DW-1:0]           dvs_reg;
    logic                    neg_reg;

    logic                    sq_ph_reg;
    logic [31:0]             sq_acc_reg;
    logic [31:0]             root_reg;
    logic [31:0]             bit_reg;

    logic signed [XW-1:0]    x_reg, y_reg;
    logic signed [ZW-1:0]    z_reg;
    logic [IC_W-1:0]         i_reg;

    logic                    out_valid_reg;
    logic [119:0]            out_data_reg;

    logic                    in_acc;
    cmd_t                    cmd;

    // Divider operand selection
    logic signed [NW-1:0]    num_sel;
    logic [NW-1:0]           num_mag;
    logic [DW:0]             trial;
    logic                    q_bit;
    logic [NW-1:0]           dvd_step;
    logic signed [NW-1:0]    q_signed;

    // Rate scaling by reciprocal
    logic [48:0]             rate_prod;
    logic signed [17:0]      rate_q;

    // Square root and CORDIC step
    logic [31:0]             sq_prod;
    logic [31:0]             root_try;
    logic signed [XW-1:0]    dx, dy;
    logic signed [ZW-1:0]    dz;

    // Tilt output
    logic signed [ZW-1:0]    z_rnd;
    logic [ZW-1:0]           t_mag;
    logic signed [15:0]      tilt;
    logic                    out_load;

    assign cmd      = cmd_t'(s_tuser);
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Pick this axis' dividend: sum*256 when finishing, gyro*256-bias when measuring
    always_comb begin
        if (fin_reg) begin
            num_sel = {sum_reg[axis_reg], 8'b0};
        end else begin
            num_sel = NW'($signed({gyro_reg[axis_reg], 8'b0})) - NW'(bias_reg[axis_reg]);
        end
        num_mag = num_sel[NW-1] ? NW'(-num_sel) : NW'(num_sel);
    end

    // One restoring-divider step
    always_comb begin
        trial    = {rem_reg, dvd_reg[NW-1]};
        q_bit    = (trial >= {1'b0, dvs_reg});
        dvd_step = {dvd_reg[NW-2:0], q_bit};
        q_signed = neg_reg ? -$signed(dvd_step) : $signed(dvd_step);
    end

    // Divide the rate magnitude (below 2^24) by 131, truncate, then restore the sign
    always_comb begin
        rate_prod = num_mag[23:0] * GYRO_RECIP;
        rate_q    = num_sel[NW-1] ? -$signed({1'b0, rate_prod[48:32]})
                                  : $signed({1'b0, rate_prod[48:32]});
    end

    // Square and root helpers
    assign sq_prod  = 32'($signed(sq_ph_reg ? acc_reg[2] : acc_reg[1])
                          * $signed(sq_ph_reg ? acc_reg[2] : acc_reg[1]));
    assign root_try = root_reg + bit_reg;

    // CORDIC deltas
    assign dx = y_reg >>> i_reg;
    assign dy = x_reg >>> i_reg;
    assign dz = ZW'(atan_entry(5'(i_reg)));

    // Round, clamp and sign the angle
    always_comb begin
        z_rnd = (z_reg + ZW'(128)) >>> 8;
        if (z_reg < 0) begin
            t_mag = '0;
        end else if (z_rnd > ZW'(TILT_LIMIT)) begin
            t_mag = ZW'(TILT_LIMIT);
        end else begin
            t_mag = z_rnd;
        end
        tilt = (acc_reg[0] > 0) ? -16'(t_mag) : 16'(t_mag);
    end

    assign out_load = (state_reg == S_HOLD) && (!out_valid_reg || m_tready);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    if (cmd == CMD_MEASURE) begin
                        state_next = S_DIV;
                    end else if (cmd == CMD_FINISH && count_reg != '0) begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (fin_reg) begin
                    if (!div_ld_reg && div_cnt_reg == DC_W'(NW - 1) && axis_reg == 2'd2) begin
                        state_next = S_IDLE;
                    end
                end else if (axis_reg == 2'd2) begin
                    state_next = S_SQ;
                end
            end
            S_SQ: begin
                if (sq_ph_reg) begin
                    state_next = S_SQRT;
                end
            end
            S_SQRT: begin
                if (bit_reg == 32'd1) begin
                    state_next = (acc_reg[0] == '0) ? S_HOLD : S_CORD;
                end
            end
            S_CORD: begin
                if (i_reg == IC_W'(STEPS - 1)) begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            for (int k = 0; k < 3; k++) begin
                sum_reg[k]  <= '0;
                bias_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            // Hold result until taken
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            // Accumulate calibration samples up to the limit
            if (in_acc && cmd == CMD_CAL && count_reg < CNT_W'(CAL_SAMPLES)) begin
                for (int k = 0; k < 3; k++) begin
                    sum_reg[k] <= sum_reg[k]
                                  + SUM_W'($signed(s_tdata[48 + 16*k +: 16]));
                end
                count_reg <= count_reg + 1'b1;
            end
            // Finish with no samples: clear only
            if (in_acc && cmd == CMD_FINISH && count_reg == '0) begin
                for (int k = 0; k < 3; k++) begin
                    sum_reg[k] <= '0;
                end
            end
            // Store bias after each division; clear sums after the last
            if (state_reg == S_DIV && !div_ld_reg && div_cnt_reg == DC_W'(NW - 1)
                && fin_reg) begin
                bias_reg[axis_reg] <= q_signed[23:0];
                if (axis_reg == 2'd2) begin
                    count_reg <= '0;
                    for (int k = 0; k < 3; k++) begin
                        sum_reg[k] <= '0;
                    end
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            for (int k = 0; k < 3; k++) begin
                acc_reg[k]  <= s_tdata[16*k +: 16];
                gyro_reg[k] <= s_tdata[48 + 16*k +: 16];
            end
            fin_reg    <= (cmd == CMD_FINISH);
            axis_reg   <= 2'd0;
            div_ld_reg <= 1'b1;
            sq_ph_reg  <= 1'b0;
        end
        case (state_reg)
            S_DIV: begin
                if (!fin_reg) begin
                    // Scale one gyro axis per cycle
                    rate_reg[axis_reg] <= rate_q;
                    axis_reg           <= axis_reg + 2'd1;
                end else if (div_ld_reg) begin
                    // Load operands
                    dvd_reg     <= num_mag;
                    neg_reg     <= num_sel[NW-1];
                    rem_reg     <= '0;
                    dvs_reg     <= DW'(count_reg);
                    div_cnt_reg <= '0;
                    div_ld_reg  <= 1'b0;
                end else begin
                    // Advance one quotient bit
                    dvd_reg     <= dvd_step;
                    rem_reg     <= q_bit ? DW'(trial - {1'b0, dvs_reg}) : DW'(trial);
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DC_W'(NW - 1)) begin
                        axis_reg   <= axis_reg + 2'd1;
                        div_ld_reg <= 1'b1;
                    end
                end
            end
            S_SQ: begin
                // Sum the two squares, then seed the root
                sq_ph_reg  <= 1'b1;
                sq_acc_reg <= sq_ph_reg ? sq_acc_reg + sq_prod : sq_prod;
                root_reg   <= '0;
                bit_reg    <= 32'h4000_0000;
            end
            S_SQRT: begin
                if (sq_acc_reg >= root_try) begin
                    sq_acc_reg <= sq_acc_reg - root_try;
                    root_reg   <= (root_reg >> 1) + bit_reg;
                end else begin
                    root_reg   <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                // Seed the rotation with the last root digit applied
                x_reg <= '0;
                y_reg <= XW'({1'b0, (acc_reg[0][15] ? -17'(acc_reg[0]) : 17'(acc_reg[0])),
                              16'b0});
                z_reg <= '0;
                i_reg <= '0;
            end
            S_CORD: begin
                if (i_reg == '0 && x_reg == '0 && y_reg[XW-1] == 1'b0) begin
                    // First step: bring in the root magnitude
                    if (y_reg > 0) begin
                        x_reg <= XW'({root_reg[15:0], 16'b0}) + y_reg;
                        y_reg <= y_reg - XW'({root_reg[15:0], 16'b0});
                        z_reg <= z_reg + dz;
                    end else begin
                        x_reg <= XW'({root_reg[15:0], 16'b0}) - y_reg;
                        y_reg <= y_reg + XW'({root_reg[15:0], 16'b0});
                        z_reg <= z_reg - dz;
                    end
                end else if (y_reg > 0) begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + dz;
                end else begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - dz;
                end
                i_reg <= i_reg + 1'b1;
            end
            default: begin
            end
        endcase
        // Load the output register
        if (out_load) begin
            out_data_reg <= {2'b00, tilt, rate_reg[2], rate_reg[1], rate_reg[0],
                             acc_reg[2], acc_reg[1], acc_reg[0]};
        end
    end

endmodule
